@@ design/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication, held off during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

@@ design/skrr_pkg.sv @@
// Types, codes and defaults of the sequence-keyed retransmit ring.
package skrr_pkg;

	localparam int CAPACITY_DEF     = 4096;
	localparam int MAX_READ_DEF     = 64;
	localparam int APPEND_BYTES_DEF = 8;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_SEQ = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SEQ_MODE    = 2'd1;

	typedef enum logic [1:0] {
		FN_APPEND  = 2'd0,
		FN_RELEASE = 2'd1,
		FN_READ    = 2'd2
	} func_t;

	typedef enum logic [2:0] {
		ST_BYTE     = 3'd0,
		ST_NOTIN    = 3'd1,
		ST_EMPTY    = 3'd2,
		ST_OVERFLOW = 3'd3,
		ST_DONE     = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CALC,
		S_DECIDE,
		S_WRITE,
		S_RDADDR,
		S_RDEMIT,
		S_RESULT
	} state_t;

	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] seq;
		logic [6:0]  byte_count;
		logic [63:0] append_data;
	} req_t;

	typedef struct packed {
		logic [7:0]  read_byte;
		logic [2:0]  status;
		logic        last;
		logic [12:0] fill;
	} rsp_t;

	typedef struct packed {
		logic capture;
		logic calc;
		logic decide;
		logic release_seq;
		logic write_byte;
		logic read_addr;
		logic emit_result;
		logic emit_byte;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] func;
		logic       overflow;
		logic       wr_zero;
		logic       notin;
		logic       len_zero;
		logic       rem_last;
		logic       out_free;
	} dp_stat_t;

endpackage

@@ design/skrr_ctrl.sv @@
// Controller state machine of the retransmit ring.
module skrr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  skrr_pkg::dp_stat_t stat,
	output skrr_pkg::dp_cmd_t  cmd
);

	skrr_pkg::state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= skrr_pkg::S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			skrr_pkg::S_IDLE: begin
				if (req_valid) state_nx = skrr_pkg::S_CALC;
			end
			skrr_pkg::S_CALC: begin
				state_nx = skrr_pkg::S_DECIDE;
			end
			skrr_pkg::S_DECIDE: begin
				unique case (stat.func)
					skrr_pkg::FN_APPEND: begin
						if (stat.overflow || stat.wr_zero) state_nx = skrr_pkg::S_RESULT;
						else state_nx = skrr_pkg::S_WRITE;
					end
					skrr_pkg::FN_READ: begin
						if (stat.notin || stat.len_zero) state_nx = skrr_pkg::S_RESULT;
						else state_nx = skrr_pkg::S_RDADDR;
					end
					default: begin
						state_nx = skrr_pkg::S_RESULT;
					end
				endcase
			end
			skrr_pkg::S_WRITE: begin
				if (stat.rem_last) state_nx = skrr_pkg::S_RESULT;
			end
			skrr_pkg::S_RDADDR: begin
				state_nx = skrr_pkg::S_RDEMIT;
			end
			skrr_pkg::S_RDEMIT: begin
				if (stat.out_free) begin
					state_nx = stat.rem_last ? skrr_pkg::S_IDLE : skrr_pkg::S_RDADDR;
				end
			end
			skrr_pkg::S_RESULT: begin
				if (stat.out_free) state_nx = skrr_pkg::S_IDLE;
			end
			default: begin
				state_nx = skrr_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		req_stall = (state_q != skrr_pkg::S_IDLE);
		unique case (state_q)
			skrr_pkg::S_IDLE:   cmd.capture = req_valid;
			skrr_pkg::S_CALC:   cmd.calc = 1'b1;
			skrr_pkg::S_DECIDE: begin
				cmd.decide = 1'b1;
				cmd.release_seq = (stat.func == skrr_pkg::FN_RELEASE);
			end
			skrr_pkg::S_WRITE:  cmd.write_byte = 1'b1;
			skrr_pkg::S_RDADDR: cmd.read_addr = 1'b1;
			skrr_pkg::S_RDEMIT: cmd.emit_byte = stat.out_free;
			skrr_pkg::S_RESULT: cmd.emit_result = stat.out_free;
			default:            cmd = '0;
		endcase
	end

endmodule

@@ design/skrr_dp.sv @@
// Datapath of the retransmit ring: byte store, pointers, fill and result register.
module skrr_dp #(
	parameter int CAPACITY     = skrr_pkg::CAPACITY_DEF,
	parameter int MAX_READ     = skrr_pkg::MAX_READ_DEF,
	parameter int APPEND_BYTES = skrr_pkg::APPEND_BYTES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  skrr_pkg::req_t                 req,
	output skrr_pkg::rsp_t                 rsp,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	input  logic                           cfg_we,
	input  logic [skrr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data,
	input  skrr_pkg::dp_cmd_t              cmd,
	output skrr_pkg::dp_stat_t             stat
);

	localparam int AW = $clog2(CAPACITY);
	localparam int FW = $clog2(CAPACITY + 1);

	logic [7:0] mem [CAPACITY];

	logic [AW-1:0]  head_q, tail_q, pos_q;
	logic [FW-1:0]  fill_q;
	logic [31:0]    start_q;
	logic           seq_mode_q;
	logic           rsp_valid_q;
	skrr_pkg::req_t req_q;
	skrr_pkg::rsp_t rsp_q;
	logic [63:0]    data_q;
	logic [31:0]    off_q;
	logic [6:0]     rem_q;
	logic [2:0]     res_status_q;
	logic [7:0]     rdata_q;

	logic [6:0]    cnt_cl, rd_cnt, rd_len;
	logic [FW:0]   fill_sum;
	logic          overflow, off_gt_fill, notin;
	logic [FW-1:0] avail, rel_n;
	logic [AW:0]   pos_sum, head_sum;
	logic [AW-1:0] pos_wr, head_wr, tail_inc, pos_inc;
	logic [31:0]   fill_ext;
	logic          out_free;
	logic          load_out;

	assign cnt_cl   = (req_q.byte_count > 7'(APPEND_BYTES)) ? 7'(APPEND_BYTES)
							: req_q.byte_count;
	assign fill_sum = (FW+1)'(fill_q) + (FW+1)'(cnt_cl);
	assign overflow = (fill_sum >= (FW+1)'(CAPACITY));

	assign off_gt_fill = (off_q > 32'(fill_q));
	assign notin       = off_q[31] || off_gt_fill;
	assign avail       = fill_q - off_q[FW-1:0];
	assign rd_cnt      = (req_q.byte_count > 7'(MAX_READ)) ? 7'(MAX_READ) : req_q.byte_count;
	assign rd_len      = (32'(rd_cnt) > 32'(avail)) ? 7'(avail) : rd_cnt;

	assign pos_sum = (AW+1)'(head_q) + (AW+1)'(off_q[AW-1:0]);
	assign pos_wr  = (pos_sum >= (AW+1)'(CAPACITY)) ? AW'(pos_sum - (AW+1)'(CAPACITY))
							: pos_sum[AW-1:0];

	assign rel_n    = off_gt_fill ? fill_q : off_q[FW-1:0];
	assign head_sum = (AW+1)'(head_q) + (AW+1)'(rel_n[AW-1:0]);
	assign head_wr  = (head_sum >= (AW+1)'(CAPACITY)) ? AW'(head_sum - (AW+1)'(CAPACITY))
							: head_sum[AW-1:0];

	assign tail_inc = (tail_q == AW'(CAPACITY - 1)) ? '0 : tail_q + 1'b1;
	assign pos_inc  = (pos_q == AW'(CAPACITY - 1)) ? '0 : pos_q + 1'b1;

	assign fill_ext = 32'(fill_q);
	assign out_free = !rsp_valid_q || !rsp_stall;
	assign load_out = cmd.emit_result || cmd.emit_byte;

	assign stat.func     = req_q.func;
	assign stat.overflow = overflow;
	assign stat.wr_zero  = (cnt_cl == 7'd0);
	assign stat.notin    = notin;
	assign stat.len_zero = (rd_len == 7'd0);
	assign stat.rem_last = (rem_q == 7'd1);
	assign stat.out_free = out_free;

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			fill_q      <= '0;
			start_q     <= '0;
			seq_mode_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we && (cfg_index == skrr_pkg::CFG_INITIAL_SEQ)) begin
				start_q <= cfg_data;
			end else if (cmd.release_seq && seq_mode_q) begin
				start_q <= start_q + 32'(rel_n);
			end
			if (cfg_we && (cfg_index == skrr_pkg::CFG_SEQ_MODE)) begin
				seq_mode_q <= cfg_data[0];
			end
			if (cmd.release_seq) begin
				head_q <= head_wr;
				fill_q <= fill_q - rel_n;
			end else if (cmd.write_byte) begin
				tail_q <= tail_inc;
				fill_q <= fill_q + 1'b1;
			end
			if (load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q  <= req;
			data_q <= req.append_data;
		end
		if (cmd.calc) begin
			off_q <= req_q.seq - start_q;
		end
		if (cmd.decide) begin
			pos_q <= pos_wr;
			rem_q <= (req_q.func == skrr_pkg::FN_APPEND) ? cnt_cl : rd_len;
			unique case (req_q.func)
				skrr_pkg::FN_APPEND:
					res_status_q <= overflow ? skrr_pkg::ST_OVERFLOW : skrr_pkg::ST_DONE;
				skrr_pkg::FN_READ:
					res_status_q <= notin ? skrr_pkg::ST_NOTIN : skrr_pkg::ST_EMPTY;
				default:
					res_status_q <= skrr_pkg::ST_DONE;
			endcase
		end
		if (cmd.write_byte) begin
			data_q <= {8'h00, data_q[63:8]};
			rem_q  <= rem_q - 1'b1;
		end
		if (cmd.emit_byte) begin
			pos_q <= pos_inc;
			rem_q <= rem_q - 1'b1;
		end
		if (cmd.emit_result) begin
			rsp_q.read_byte <= 8'h00;
			rsp_q.status    <= res_status_q;
			rsp_q.last      <= 1'b1;
			rsp_q.fill      <= fill_ext[12:0];
		end else if (cmd.emit_byte) begin
			rsp_q.read_byte <= rdata_q;
			rsp_q.status    <= skrr_pkg::ST_BYTE;
			rsp_q.last      <= (rem_q == 7'd1);
			rsp_q.fill      <= fill_ext[12:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.write_byte) begin
			mem[tail_q] <= data_q[7:0];
		end
		if (cmd.read_addr) begin
			rdata_q <= mem[pos_q];
		end
	end

endmodule

@@ design/seq_keyed_retransmit_ring.sv @@
// Top level of the sequence-keyed retransmit ring.
//
//   channel   signals                          moves
//   request   req_valid, req_stall, req        append, release or read request
//   result    rsp_valid, rsp_stall, rsp        one byte or one status per result
//   config    cfg_we, cfg_index, cfg_data      initial_seq, seq_mode writes
//
// A request is accepted and decoded through the capture, calc and decide steps, then each
// appended byte (up to 8) goes through the single store write port, or each read byte
// through the registered store read port, by an address step and an emit step; appends,
// releases and status-only requests close with a result step, byte reads do not.
// Reset clears pointers, fill and start sequence at once; the store holds no reset.
// A stalled result holds the block in its emit step until it is taken.
module seq_keyed_retransmit_ring #(
	parameter int CAPACITY     = skrr_pkg::CAPACITY_DEF,
	parameter int MAX_READ     = skrr_pkg::MAX_READ_DEF,
	parameter int APPEND_BYTES = skrr_pkg::APPEND_BYTES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  skrr_pkg::req_t                 req,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output skrr_pkg::rsp_t                 rsp,
	input  logic                           cfg_we,
	input  logic [skrr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data
);

	skrr_pkg::dp_cmd_t  cmd;
	skrr_pkg::dp_stat_t stat;

	skrr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	skrr_dp #(
		.CAPACITY     (CAPACITY),
		.MAX_READ     (MAX_READ),
		.APPEND_BYTES (APPEND_BYTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

@@ design/skrr_checker.sv @@
// Port-level checker of the retransmit ring and its bind.
`include "assert_macros.svh"

module skrr_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_stall,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input skrr_pkg::rsp_t rsp
);

	`ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))
	`ASSERT_NEXT(a_busy_after_req, clk, arst_n, req_valid && !req_stall, req_stall)
	`ASSERT_IMPLIES(a_status_last, clk, arst_n, rsp_valid && (rsp.status != skrr_pkg::ST_BYTE), rsp.last)
	`ASSERT_IMPLIES(a_status_zero_byte, clk, arst_n, rsp_valid && (rsp.status != skrr_pkg::ST_BYTE), rsp.read_byte == 8'h00)

endmodule

bind seq_keyed_retransmit_ring skrr_checker u_skrr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

@@ dv/tb.sv @@
// Self-checking bench for the retransmit ring: directed cases, a bulk fill and random traffic.
`timescale 1ns / 1ps

module tb;

	localparam int CAP            = skrr_pkg::CAPACITY_DEF;
	localparam int READ_MAX       = skrr_pkg::MAX_READ_DEF;
	localparam int APPEND_MAX     = skrr_pkg::APPEND_BYTES_DEF;
	localparam int RANDOM_ITEMS   = 300;
	localparam int FILL_ITEMS     = 40;
	localparam int SETTLE_CYCLES  = 12;
	localparam int WATCHDOG_LIMIT = 2000;

	localparam logic [1:0]                     FN_SPARE    = 2'd3;
	localparam logic [skrr_pkg::CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
	localparam logic [skrr_pkg::CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           req_valid = 1'b0;
	logic                           req_stall;
	skrr_pkg::req_t                 req       = '0;
	logic                           rsp_valid;
	logic                           rsp_stall = 1'b0;
	skrr_pkg::rsp_t                 rsp;
	logic                           cfg_we    = 1'b0;
	logic [skrr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0]                    cfg_data  = '0;

	logic [7:0]     ring_bytes [CAP];
	logic [11:0]    ring_head      = '0;
	logic [11:0]    ring_tail      = '0;
	logic [12:0]    ring_fill      = '0;
	logic [31:0]    ring_start_seq = '0;
	logic           ring_seq_mode  = 1'b0;
	skrr_pkg::rsp_t due_results [$];

	bit             req_calm     = 1'b0;
	bit             rsp_calm     = 1'b0;
	int             rsp_hold     = 0;
	int             quiet_cycles = 0;
	int             mismatch_cnt = 0;
	skrr_pkg::rsp_t oldest;

	seq_keyed_retransmit_ring dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int draw_gap(input bit calm);
		if (calm)
			return 0;
		return $urandom_range(0, 5);
	endfunction

	function automatic skrr_pkg::req_t pack_req(input logic [1:0] fn, input logic [31:0] seq_no,
			input logic [6:0] count, input logic [63:0] data);
		skrr_pkg::req_t r;
		r.func        = fn;
		r.seq         = seq_no;
		r.byte_count  = count;
		r.append_data = data;
		return r;
	endfunction

	task automatic queue_result(input logic [7:0] value, input skrr_pkg::status_t st,
			input logic fin);
		skrr_pkg::rsp_t e;
		e.read_byte = value;
		e.status    = st;
		e.last      = fin;
		e.fill      = ring_fill;
		due_results.push_back(e);
	endtask

	// Update the ring copy for one accepted request and queue the results it yields.
	task automatic advance_ring(input skrr_pkg::req_t item);
		int          n_app;
		int          len;
		int          i;
		logic [31:0] seq_off;
		logic [11:0] pos;
		case (item.func)
			skrr_pkg::FN_APPEND: begin
				n_app = (item.byte_count > APPEND_MAX) ? APPEND_MAX : int'(item.byte_count);
				if (int'(ring_fill) + n_app >= CAP) begin
					queue_result(8'h00, skrr_pkg::ST_OVERFLOW, 1'b1);
				end else begin
					for (i = 0; i < n_app; i++) begin
						ring_bytes[ring_tail] = item.append_data[8*i +: 8];
						ring_tail++;
					end
					ring_fill = ring_fill + 13'(n_app);
					queue_result(8'h00, skrr_pkg::ST_DONE, 1'b1);
				end
			end
			skrr_pkg::FN_RELEASE: begin
				seq_off = item.seq - ring_start_seq;
				if (seq_off > ring_fill)
					seq_off = ring_fill;
				if (ring_seq_mode)
					ring_start_seq += seq_off;
				ring_head += seq_off[11:0];
				ring_fill -= seq_off[12:0];
				queue_result(8'h00, skrr_pkg::ST_DONE, 1'b1);
			end
			skrr_pkg::FN_READ: begin
				seq_off = item.seq - ring_start_seq;
				if (seq_off[31] || seq_off > ring_fill) begin
					queue_result(8'h00, skrr_pkg::ST_NOTIN, 1'b1);
				end else begin
					len = (item.byte_count > READ_MAX) ? READ_MAX : int'(item.byte_count);
					if (len > int'(ring_fill) - int'(seq_off))
						len = int'(ring_fill) - int'(seq_off);
					if (len == 0) begin
						queue_result(8'h00, skrr_pkg::ST_EMPTY, 1'b1);
					end else begin
						pos = ring_head + seq_off[11:0];
						for (i = 0; i < len; i++) begin
							queue_result(ring_bytes[pos], skrr_pkg::ST_BYTE, i == len - 1);
							pos++;
						end
					end
				end
			end
			default: begin
				queue_result(8'h00, skrr_pkg::ST_DONE, 1'b1);
			end
		endcase
	endtask

	task automatic send_req(input skrr_pkg::req_t item);
		int gap;
		gap = draw_gap(req_calm);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		advance_ring(item);
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [skrr_pkg::CFG_IDX_W-1:0] idx,
			input logic [31:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			skrr_pkg::CFG_INITIAL_SEQ: ring_start_seq = value;
			skrr_pkg::CFG_SEQ_MODE:    ring_seq_mode  = value[0];
			default: ;
		endcase
	endtask

	task automatic compare_field(input string what, input logic [12:0] want,
			input logic [12:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
			mismatch_cnt++;
		end
	endtask

	function automatic skrr_pkg::req_t random_request();
		skrr_pkg::req_t r;
		int             roll;
		int             aim;
		roll          = $urandom_range(0, 99);
		r.seq         = $urandom;
		r.append_data = {$urandom, $urandom};
		r.byte_count  = 7'($urandom_range(0, 127));
		if (roll < 35) begin
			r.func = skrr_pkg::FN_APPEND;
			if ($urandom_range(0, 9) != 0)
				r.byte_count = 7'($urandom_range(1, APPEND_MAX));
		end else if (roll < 55) begin
			r.func = skrr_pkg::FN_RELEASE;
			if ($urandom_range(0, 9) != 0)
				r.seq = ring_start_seq + $urandom_range(0, 12);
		end else if (roll < 96) begin
			r.func = skrr_pkg::FN_READ;
			aim    = $urandom_range(0, 9);
			if (aim == 1)
				r.seq = ring_start_seq + ring_fill + $urandom_range(0, 3);
			else if (aim > 1)
				r.seq = ring_start_seq + $urandom_range(0, ring_fill);
			if ($urandom_range(0, 7) != 0)
				r.byte_count = 7'($urandom_range(0, READ_MAX));
		end else begin
			r.func = FN_SPARE;
		end
		return r;
	endfunction

	task automatic test_after_reset();
		send_req(pack_req(skrr_pkg::FN_READ, 32'h0, 7'd64, 64'h0));
		send_req(pack_req(skrr_pkg::FN_READ, 32'hFFFF_FFFF, 7'd1, 64'h0));
		send_req(pack_req(skrr_pkg::FN_RELEASE, 32'h0000_0010, 7'd0, 64'h0));
		send_req(pack_req(FN_SPARE, 32'hFFFF_FFFF, 7'h7F, 64'hFFFF_FFFF_FFFF_FFFF));
	endtask

	task automatic test_append_read();
		wait_drained();
		write_cfg(skrr_pkg::CFG_INITIAL_SEQ, 32'hFFFF_FFFC);
		write_cfg(skrr_pkg::CFG_SEQ_MODE, 32'd1);
		send_req(pack_req(skrr_pkg::FN_APPEND, 32'h0, 7'd8, 64'hFFFF_FFFF_FFFF_FFFF));
		send_req(pack_req(skrr_pkg::FN_APPEND, 32'hFFFF_FFFF, 7'd0, 64'hA5A5_5A5A_C3C3_3C3C));
		send_req(pack_req(skrr_pkg::FN_APPEND, 32'h0, 7'd1, 64'h0));
		send_req(pack_req(skrr_pkg::FN_APPEND, $urandom, 7'd127, {$urandom, $urandom}));
		send_req(pack_req(skrr_pkg::FN_APPEND, 32'h0, 7'd9, 64'h0123_4567_89AB_CDEF));
		send_req(pack_req(skrr_pkg::FN_READ, ring_start_seq, 7'd64, 64'h0));
		send_req(pack_req(skrr_pkg::FN_READ, ring_start_seq + 3, 7'd5, 64'h0));
		send_req(pack_req(skrr_pkg::FN_READ, ring_start_seq, 7'd0, 64'h0));
		send_req(pack_req(skrr_pkg::FN_READ, ring_start_seq + ring_fill, 7'd4, 64'h0));
		send_req(pack_req(skrr_pkg::FN_READ, ring_start_seq + ring_fill + 1, 7'd4, 64'h0));
		send_req(pack_req(skrr_pkg::FN_READ, ring_start_seq - 1, 7'd4, 64'h0));
		send_req(pack_req(skrr_pkg::FN_READ, ring_start_seq + 32'h8000_0000, 7'd64, 64'h0));
		send_req(pack_req(skrr_pkg::FN_READ, ring_start_seq + 10, 7'd127, 64'h0));
	endtask

	task automatic test_release();
		send_req(pack_req(skrr_pkg::FN_RELEASE, ring_start_seq, 7'd0, 64'h0));
		send_req(pack_req(skrr_pkg::FN_RELEASE, ring_start_seq + 4, 7'd0, 64'h0));
		send_req(pack_req(skrr_pkg::FN_READ, ring_start_seq, 7'd3, 64'h0));
		wait_drained();
		write_cfg(skrr_pkg::CFG_SEQ_MODE, 32'd0);
		send_req(pack_req(skrr_pkg::FN_RELEASE, ring_start_seq + 2, 7'd0, 64'h0));
		send_req(pack_req(skrr_pkg::FN_READ, ring_start_seq, 7'd2, 64'h0));
		send_req(pack_req(skrr_pkg::FN_RELEASE, ring_start_seq - 1, 7'd127, 64'h0));
		send_req(pack_req(skrr_pkg::FN_READ, ring_start_seq, 7'd1, 64'h0));
	endtask

	task automatic test_bulk_fill();
		int k;
		wait_drained();
		write_cfg(skrr_pkg::CFG_INITIAL_SEQ, 32'd0);
		write_cfg(skrr_pkg::CFG_SEQ_MODE, 32'd1);
		for (k = 0; k < FILL_ITEMS; k++)
			send_req(pack_req(skrr_pkg::FN_APPEND, $urandom, 7'd8, {$urandom, $urandom}));
		send_req(pack_req(skrr_pkg::FN_APPEND, 32'h0, 7'd7, {$urandom, $urandom}));
		send_req(pack_req(skrr_pkg::FN_APPEND, 32'h0, 7'd1, {$urandom, $urandom}));
		send_req(pack_req(skrr_pkg::FN_APPEND, 32'h0, 7'd0, {$urandom, $urandom}));
		send_req(pack_req(skrr_pkg::FN_READ, ring_start_seq + ring_fill - 64, 7'd64, 64'h0));
		send_req(pack_req(skrr_pkg::FN_READ, ring_start_seq + ring_fill, 7'd64, 64'h0));
		send_req(pack_req(skrr_pkg::FN_READ, ring_start_seq + ring_fill + 1, 7'd64, 64'h0));
		// drop almost everything before the random traffic
		send_req(pack_req(skrr_pkg::FN_RELEASE, ring_start_seq + ring_fill - 5, 7'd0, 64'h0));
	endtask

	task automatic test_random_traffic();
		int phase;
		int k;
		for (phase = 0; phase < 4; phase++) begin
			wait_drained();
			case (phase)
				0: begin
					write_cfg(skrr_pkg::CFG_INITIAL_SEQ, $urandom);
					write_cfg(skrr_pkg::CFG_SEQ_MODE, 32'd1);
				end
				1: begin
					write_cfg(skrr_pkg::CFG_SEQ_MODE, 32'd0);
					write_cfg(skrr_pkg::CFG_INITIAL_SEQ, 32'hFFFF_FFFF);
				end
				2: begin
					write_cfg(CFG_SPARE_2, $urandom);
					write_cfg(CFG_SPARE_3, $urandom);
					write_cfg(skrr_pkg::CFG_INITIAL_SEQ, 32'd0);
					write_cfg(skrr_pkg::CFG_SEQ_MODE, $urandom | 32'd1);
				end
				default: begin
					write_cfg(skrr_pkg::CFG_INITIAL_SEQ, 32'h7FFF_FFF8);
					write_cfg(skrr_pkg::CFG_SEQ_MODE, 32'd1);
				end
			endcase
			for (k = 0; k < RANDOM_ITEMS / 4; k++) begin
				if (k % 30 == 0) begin
					req_calm = ($urandom_range(0, 3) == 0);
					rsp_calm = ($urandom_range(0, 3) == 0);
				end
				send_req(random_request());
			end
		end
		req_calm = 1'b0;
		rsp_calm = 1'b0;
	endtask

	// Check each accepted result against the oldest expectation, then pick the next stall.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (due_results.size() == 0) begin
					$display("%0t: unexpected result: expected none, actual %h", $time, rsp);
					mismatch_cnt++;
				end else begin
					oldest = due_results.pop_front();
					compare_field("read_byte", 13'(oldest.read_byte), 13'(rsp.read_byte));
					compare_field("status", 13'(oldest.status), 13'(rsp.status));
					compare_field("last", 13'(oldest.last), 13'(rsp.last));
					compare_field("fill", oldest.fill, rsp.fill);
				end
				rsp_hold = draw_gap(rsp_calm);
			end else if (rsp_hold > 0) begin
				rsp_hold--;
			end
			rsp_stall <= (rsp_hold != 0);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: watchdog: no transfer for %0d cycles", $time, quiet_cycles);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_after_reset();
		test_append_read();
		test_release();
		test_bulk_fill();
		test_random_traffic();
		wait_drained();
		if (mismatch_cnt == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
